/* hdl/stpq_pkg.sv */
// ----------------------------------------------------------------------------
// stpq_pkg
// shared types and constants for the sorted event list
// ----------------------------------------------------------------------------
package stpq_pkg;

    // number of cells in the chain, one stored event per cell
    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [31:0] ev_time;
        logic        [7:0]  ev_kind;
        logic signed [31:0] ev_a;
        logic signed [31:0] ev_b;
    } t_entry;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry item;
    } t_cell_ctrl;

endpackage

/* hdl/stpq_cell.sv */
// ----------------------------------------------------------------------------
// stpq_cell
// one slot of the sorted chain: compares, takes the new event or a neighbor's, or holds
// ----------------------------------------------------------------------------
module stpq_cell
    import stpq_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_occupied,
    input  t_entry     i_left_item,
    input  logic       i_left_gt,
    input  t_entry     i_right_item,
    output t_entry     o_item,
    output logic       o_gt
);

    t_entry r_item;
    t_entry n_item;

    // empty slots count as later than any new event
    assign o_gt   = !i_occupied || (r_item.ev_time > i_ctrl.item.ev_time);
    assign o_item = r_item;

    always_comb begin
        n_item = r_item;
        if (i_ctrl.ins) begin
            if (i_left_gt) begin
                n_item = i_left_item;
            end else if (o_gt) begin
                n_item = i_ctrl.item;
            end
        end else if (i_ctrl.rem) begin
            n_item = i_right_item;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

/* hdl/stable_time_priority_queue.sv */
// ----------------------------------------------------------------------------
// stable_time_priority_queue
// future-event list sorted by signed time, fifo among equal times
// ----------------------------------------------------------------------------
// The list is a chain of CAPACITY cells, cell 0 holding the earliest event.
// An insert broadcasts its time to all cells, every cell compares in the same
// cycle, and the chain opens a gap right after the last event whose time is
// less than or equal to the new one, so equal times leave in arrival order.
// A remove shifts the whole chain one cell toward cell 0 and returns the
// event that was in cell 0. Every accepted word gives exactly one result
// word: status (ok, full, empty), the removed event (zero for inserts and
// refused removes) and whether the list is empty afterwards. One word is
// accepted per cycle as long as the result register is free or being taken,
// the limit being the broadcast compare across all cells. Insert into a full
// list and remove from an empty list leave the list unchanged. There is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module stable_time_priority_queue
    import stpq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_command,
    input  logic signed [31:0] i_event_time,
    input  logic        [7:0]  i_event_kind,
    input  logic signed [31:0] i_payload_a,
    input  logic signed [31:0] i_payload_b,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic        [1:0]  o_status,
    output logic signed [31:0] o_out_time,
    output logic        [7:0]  o_out_kind,
    output logic signed [31:0] o_out_payload_a,
    output logic signed [31:0] o_out_payload_b,
    output logic               o_list_empty
);

    // control state
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic             n_out_valid;

    // result register
    t_status          r_status;
    t_status          n_status;
    t_entry           r_out_item;
    t_entry           n_out_item;
    logic             r_list_empty;
    logic             n_list_empty;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    t_cell_ctrl       w_ctrl;

    t_entry           w_item [CAPACITY];
    logic             w_gt   [CAPACITY];

    // a finished word only blocks new input while the consumer stalls it
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);

    always_comb begin
        w_ctrl.ins          = w_accept && (i_command == CMD_INSERT) && !w_full;
        w_ctrl.rem          = w_accept && (i_command == CMD_REMOVE) && !w_empty;
        w_ctrl.item.ev_time = i_event_time;
        w_ctrl.item.ev_kind = i_event_kind;
        w_ctrl.item.ev_a    = i_payload_a;
        w_ctrl.item.ev_b    = i_payload_b;
    end

    // the chain of cells
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_entry w_left_item;
        logic   w_left_gt;
        t_entry w_right_item;

        if (gi == 0) begin : g_head
            assign w_left_item = '0;
            assign w_left_gt   = 1'b0;
        end else begin : g_body
            assign w_left_item = w_item[gi-1];
            assign w_left_gt   = w_gt[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_tail
            assign w_right_item = w_item[gi];
        end else begin : g_inner
            assign w_right_item = w_item[gi+1];
        end

        stpq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_occupied   (CNT_W'(gi) < r_count),
            .i_left_item  (w_left_item),
            .i_left_gt    (w_left_gt),
            .i_right_item (w_right_item),
            .o_item       (w_item[gi]),
            .o_gt         (w_gt[gi])
        );
    end

    // next count and result word
    always_comb begin
        n_count      = r_count;
        n_out_valid  = r_out_valid && i_out_stall;
        n_status     = r_status;
        n_out_item   = r_out_item;
        n_list_empty = r_list_empty;
        if (w_ctrl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.rem) begin
            n_count = r_count - CNT_W'(1);
        end
        if (w_accept) begin
            n_out_valid  = 1'b1;
            n_out_item   = '0;
            n_status     = ST_OK;
            if (i_command == CMD_INSERT) begin
                if (w_full) begin
                    n_status = ST_FULL;
                end
            end else begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_out_item = w_item[0];
                end
            end
            n_list_empty = (n_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status     <= n_status;
        r_out_item   <= n_out_item;
        r_list_empty <= n_list_empty;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_out_time      = r_out_item.ev_time;
    assign o_out_kind      = r_out_item.ev_kind;
    assign o_out_payload_a = r_out_item.ev_a;
    assign o_out_payload_b = r_out_item.ev_b;
    assign o_list_empty    = r_list_empty;

    // occupancy never exceeds the chain length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("occupancy beyond capacity");

    // a waiting result agrees with the current occupancy
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_list_empty == (r_count == '0)))
        else $error("list_empty disagrees with occupancy");

    // a refused insert leaves the occupancy alone
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_command == CMD_INSERT) && w_full) |=> (r_count == $past(r_count)))
        else $error("full insert changed occupancy");

    // a remove reported ok shrinks the list by one
    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.rem |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("remove did not shrink the list");

endmodule
